@@ rtl/core/fkps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_pkg
// Shared types and constants of the frame key/payload sorter.
// ----------------------------------------------------------------------------
package fkps_pkg;
   localparam int FRAME_SIZE = 64;
   localparam int DEPTH      = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int KEY_W      = 32;
   localparam int PAY_W      = 32;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [KEY_W-1:0] sort_key;
      logic signed [PAY_W-1:0] payload;
      logic                    frame_last;
   } req_word_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] sorted_key;
      logic signed [PAY_W-1:0] sorted_payload;
      logic [IDX_W-1:0]        source_position;
      logic                    run_last;
   } rsp_word_type;

   // Classified word handed from the front to the back.
   typedef struct packed {
      logic signed [KEY_W-1:0] sort_key;
      logic signed [PAY_W-1:0] payload;
      logic [IDX_W-1:0]        slot;
      logic                    close;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_ALIGN,
      ST_EMIT
   } back_state_type;
endpackage

@@ rtl/core/fkps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_req_if / fkps_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface fkps_req_if;
   logic                 valid;
   logic                 ready;
   fkps_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fkps_rsp_if;
   logic                 valid;
   logic                 ready;
   fkps_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/fkps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_front
// Accept bins, number them within the frame and flag frame close.
// ----------------------------------------------------------------------------
module fkps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  fkps_pkg::req_word_type in_data,
   output logic                q_valid,
   input  logic                q_ready,
   output fkps_pkg::cmd_type   q_data
);
   import fkps_pkg::*;

   logic [IDX_W-1:0] fill_ff, fill_in;
   logic             close;

   assign close    = in_data.frame_last || ({1'b0, fill_ff} == CNT_W'(FRAME_SIZE - 1));
   assign in_ready = q_ready;
   assign q_valid  = in_valid;
   assign q_data   = '{sort_key: in_data.sort_key, payload: in_data.payload,
                       slot: fill_ff, close: close};

   always_comb begin
      fill_in = fill_ff;
      if (in_valid && q_ready) begin
         fill_in = close ? '0 : fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end
endmodule

@@ rtl/core/fkps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module fkps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  fkps_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output fkps_pkg::cmd_type rd_data
);
   import fkps_pkg::*;

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;

   assign wr_ready = cnt_ff != QCNT_W'(QDEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = push ? ((wp_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? ((rp_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ rtl/core/fkps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_back
// Insertion-sort cell chain; shift out in order on close.
// ----------------------------------------------------------------------------
module fkps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              descending,
   input  logic              q_valid,
   output logic              q_ready,
   input  fkps_pkg::cmd_type q_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fkps_pkg::rsp_word_type out_data
);
   import fkps_pkg::*;

   // Cells are kept sorted ascending, stable (new ties go behind older ones).
   logic signed [KEY_W-1:0] key_ff [DEPTH];
   logic signed [PAY_W-1:0] pay_ff [DEPTH];
   logic [IDX_W-1:0]        pos_ff [DEPTH];
   logic [DEPTH-1:0]        ins_gt;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        rd_ff, rd_in;
   logic [IDX_W-1:0]        algn_ff, algn_in;
   logic                    dir_ff, dir_in;
   logic                    ins;
   logic                    shift_dn, shift_up;
   back_state_type          st_ff, st_in;
   rsp_word_type            o_ff, o_in;
   logic                    ov_ff, ov_in;
   logic                    load;
   logic                    last_word;

   assign ins = q_valid && q_ready;

   // Cell i is displaced if its key is strictly greater than the new one.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ins_gt[i] = (i < int'(q_data.slot)) &&
                     ($signed(key_ff[i]) > $signed(q_data.sort_key));
      end
   end

   always_ff @(posedge clock) begin
      if (ins) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (ins_gt[i]) begin
               if (i < DEPTH - 1) begin
                  key_ff[i+1] <= key_ff[i];
                  pay_ff[i+1] <= pay_ff[i];
                  pos_ff[i+1] <= pos_ff[i];
               end
            end
            if ((i == int'(q_data.slot) || ins_gt[i]) && (i == 0 || !ins_gt[(i+DEPTH-1)%DEPTH]))
            begin
               key_ff[i] <= q_data.sort_key;
               pay_ff[i] <= q_data.payload;
               pos_ff[i] <= q_data.slot;
            end
         end
      end else if (shift_dn) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            key_ff[i] <= key_ff[i+1];
            pay_ff[i] <= pay_ff[i+1];
            pos_ff[i] <= pos_ff[i+1];
         end
      end else if (shift_up) begin
         for (int i = 1; i < DEPTH; i++) begin
            key_ff[i] <= key_ff[i-1];
            pay_ff[i] <= pay_ff[i-1];
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   assign load      = !ov_ff || out_ready;
   assign last_word = CNT_W'(rd_ff) + 1'b1 == n_ff;
   assign out_valid = ov_ff;
   assign out_data  = o_ff;

   always_comb begin
      st_in    = st_ff;
      n_in     = n_ff;
      rd_in    = rd_ff;
      algn_in  = algn_ff;
      dir_in   = dir_ff;
      q_ready  = 1'b0;
      shift_dn = 1'b0;
      shift_up = 1'b0;
      ov_in    = ov_ff && !out_ready;
      o_in     = o_ff;
      case (st_ff)
         ST_FILL: begin
            q_ready = 1'b1;
            if (q_valid && q_data.close) begin
               n_in    = CNT_W'(q_data.slot) + 1'b1;
               rd_in   = '0;
               dir_in  = descending;
               algn_in = IDX_W'(DEPTH - 1) - q_data.slot;
               if (descending && q_data.slot != IDX_W'(DEPTH - 1)) begin
                  st_in = ST_ALIGN;
               end else begin
                  st_in = ST_EMIT;
               end
            end
         end
         ST_ALIGN: begin
            // Walk the run up until its largest key sits in the top cell.
            shift_up = 1'b1;
            algn_in  = algn_ff - 1'b1;
            if (algn_ff == IDX_W'(1)) begin
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               ov_in = 1'b1;
               if (dir_ff) begin
                  o_in = '{sorted_key: key_ff[DEPTH-1], sorted_payload: pay_ff[DEPTH-1],
                           source_position: pos_ff[DEPTH-1], run_last: last_word};
               end else begin
                  o_in = '{sorted_key: key_ff[0], sorted_payload: pay_ff[0],
                           source_position: pos_ff[0], run_last: last_word};
               end
               shift_up = dir_ff;
               shift_dn = !dir_ff;
               rd_in    = rd_ff + 1'b1;
               if (last_word) begin
                  st_in = ST_FILL;
               end
            end
         end
         default: st_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      o_ff    <= o_in;
      n_ff    <= n_in;
      rd_ff   <= rd_in;
      algn_ff <= algn_in;
      dir_ff  <= dir_in;
      if (reset) begin
         st_ff <= ST_FILL;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end
endmodule

@@ rtl/core/frame_key_payload_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_key_payload_sorter
// Collect a frame of key/payload bins and return them ordered by key.
// ----------------------------------------------------------------------------
// channel | dir | words
// req     | in  | sort_key, payload, frame_last
// rsp     | out | sorted_key, sorted_payload, source_position, run_last
// csr     | in  | descending (bit 0 of csr_wdata)
//
// Each bin is inserted into a sorted chain of 64 cells as it arrives; a
// two-word queue parts acceptance from insertion.
// Once a frame closes, ascending words leave from the low cell at one per
// cycle while rsp is ready; descending first shifts the chain up by 64 - n
// cells, then the words leave from the top cell at one per cycle while rsp
// is ready. Bins of the next frame wait in the queue.
// Reset clears the control state only; the cells need no clearing.
// A stalled rsp holds the current word and the back end; the queue then fills
// and req.ready drops.
// ----------------------------------------------------------------------------
module frame_key_payload_sorter (
   input  logic clock,
   input  logic reset,
   fkps_req_if.sink   req,
   fkps_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [31:0] csr_wdata
);
   import fkps_pkg::*;

   logic    desc_ff, desc_in;
   logic    fq_valid, fq_ready, bq_valid, bq_ready;
   cmd_type fq_data, bq_data;

   // Hold the order register; take bit 0 only.
   assign desc_in = csr_we ? csr_wdata[0] : desc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
      end else begin
         desc_ff <= desc_in;
      end
   end

   fkps_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
   );

   fkps_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
   );

   fkps_back u_back (
      .clock, .reset, .descending(desc_ff),
      .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

@@ dv/fkps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkps_checker
// Watches the request and response channels, keeps its own copy of the open
// frame, predicts the ordered words of every closed frame and compares them.
// ----------------------------------------------------------------------------
module fkps_checker (
   input  logic clock,
   input  logic reset,
   fkps_req_if.sink req,
   fkps_rsp_if.sink rsp,
   input  logic csr_we,
   input  logic [31:0] csr_wdata,
   output int   fail_count,
   output int   pending_count
);
   import fkps_pkg::*;

   rsp_word_type   frame_bins[$];
   rsp_word_type   sorted_words[$];
   logic           descending_q;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Stable insertion sort by signed key, then emit in the chosen direction.
   task automatic close_frame();
      rsp_word_type ordered[$];
      rsp_word_type w;
      int j;
      int n;
      ordered = {};
      foreach (frame_bins[i]) begin
         w = frame_bins[i];
         j = ordered.size();
         while (j > 0 && $signed(w.sorted_key) < $signed(ordered[j-1].sorted_key))
            j--;
         ordered.insert(j, w);
      end
      n = ordered.size();
      for (int k = 0; k < n; k++) begin
         w = descending_q ? ordered[n-1-k] : ordered[k];
         w.run_last = (k == n - 1);
         sorted_words.push_back(w);
      end
      frame_bins = {};
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      rsp_word_type exp_w;
      if (reset) begin
         frame_bins = {};
         descending_q = 1'b0;
         fail_count = 0;
      end else begin
         if (csr_we) descending_q = csr_wdata[0];
         if (req.valid && req.ready) begin
            w.sorted_key      = req.data.sort_key;
            w.sorted_payload  = req.data.payload;
            w.source_position = IDX_W'(frame_bins.size());
            w.run_last        = 1'b0;
            frame_bins.push_back(w);
            if (req.data.frame_last || frame_bins.size() >= FRAME_SIZE) close_frame();
         end
         if (rsp.valid && rsp.ready) begin
            w = rsp.data;
            if (sorted_words.size() == 0) begin
               report_mismatch("word with none expected");
            end else begin
               exp_w = sorted_words.pop_front();
               if (w.sorted_key !== exp_w.sorted_key)
                  report_mismatch($sformatf("key %h exp %h", w.sorted_key, exp_w.sorted_key));
               if (w.sorted_payload !== exp_w.sorted_payload)
                  report_mismatch($sformatf("payload %h exp %h",
                                            w.sorted_payload, exp_w.sorted_payload));
               if (w.source_position !== exp_w.source_position)
                  report_mismatch($sformatf("position %0d exp %0d",
                                            w.source_position, exp_w.source_position));
               if (w.run_last !== exp_w.run_last)
                  report_mismatch($sformatf("run_last %b exp %b", w.run_last, exp_w.run_last));
            end
         end
      end
      pending_count = sorted_words.size();
   end
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the frame sorter: directed frames, random frames of
// mostly small sizes, order switching between frames, and response stalls.
// ----------------------------------------------------------------------------
module tb;
   import fkps_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          idle_on = 1'b1;   // cleared for the calm tail of the run
   bit          hold_go = 1'b0;   // asks the receiver for one long hold-off

   fkps_req_if req ();
   fkps_rsp_if rsp ();

   frame_key_payload_sorter u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   fkps_checker u_checker (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.sink),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #10 clock = ~clock;

   // Receiver: hold off in random bursts, or once for a long stretch.
   initial begin
      int gap;
      bit hold_done;
      hold_done = 1'b0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one word, with an optional idle burst first; wait for acceptance.
   task automatic send_bin(input logic [31:0] key, input logic [31:0] pay, input bit last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= '{sort_key: key, payload: pay, frame_last: last};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drop_valid();
      req.valid <= 1'b0;
   endtask

   // Write the order bit once every expected word has left and the block is idle.
   task automatic set_order(input logic [31:0] value);
      drop_valid();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] rand_key(input int style);
      case (style)
         0: rand_key = $urandom_range(0, 3);         // many ties
         1: rand_key = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
         default: rand_key = $urandom;
      endcase
   endfunction

   task automatic send_frame(input int n, input bit with_last, input int style);
      for (int i = 0; i < n; i++)
         send_bin(rand_key(style), $urandom, with_last && (i == n - 1));
   endtask

   initial begin
      int count;
      int n;
      req.valid <= 1'b0;
      req.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, single-bin frame, ties, self-closing full frame.
      send_bin(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_bin(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_bin(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_bin(32'h0000_0000, 32'h1234_5678, 1'b1);
      send_bin(32'h0001_0000, 32'hA5A5_A5A5, 1'b1);
      send_frame(4, 1'b1, 0);
      set_order(32'hFFFF_FFFF);
      send_frame(5, 1'b1, 0);
      send_bin(32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1);
      set_order(32'h0000_0000);
      send_frame(FRAME_SIZE, 1'b0, 2);      // closes on its own

      // Long receiver hold while the sender keeps pushing.
      hold_go = 1'b1;
      send_frame(20, 1'b1, 2);
      send_frame(10, 1'b1, 0);

      // Random small frames, order switched between phases.
      count = 0;
      while (count < 56) begin
         if ($urandom_range(0, 5) == 0) set_order($urandom);
         if (count > 40) idle_on = 1'b0;
         n = $urandom_range(1, 8);
         send_frame(n, 1'b1, $urandom_range(0, 2));
         count += n;
      end
      set_order(32'h0000_0001);
      send_frame(FRAME_SIZE, 1'b1, 1);
      drop_valid();
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("frame_key_payload_sorter verification clean");
      else
         $display("frame_key_payload_sorter verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("frame_key_payload_sorter verification failed");
      $finish;
   end
endmodule

@@ frame_key_payload_sorter.f @@
rtl/core/fkps_pkg.sv
rtl/core/fkps_if.sv
rtl/core/fkps_front.sv
rtl/core/fkps_queue.sv
rtl/core/fkps_back.sv
rtl/core/frame_key_payload_sorter.sv
dv/fkps_checker.sv
dv/tb.sv
